FILE: sv/slsfp_pkg.sv
// Shared types and constants for the sync/length/sum32 frame parser.
// Used by the parser core, the response queue and the top level; no dependencies.
package slsfp_pkg;

   localparam logic [7:0] SYNC_BYTE          = 8'h55;
   localparam logic [7:0] MIN_FRAME_LEN      = 8'd5;
   localparam logic [7:0] CHECKSUM_BYTES     = 8'd4;
   localparam int         MAX_FRAME_LEN_DFLT = 200;

   // Parser phase, one-hot coded.
   typedef enum logic [2:0] {
      PH_HUNT = 3'b001,
      PH_LEN  = 3'b010,
      PH_BODY = 3'b100
   } phase_type;

   // One result item as it travels from the core to the response queue.
   typedef struct packed {
      logic       frame_ok;
      logic [7:0] message_id;
      logic       checksum_error;
   } result_type;

endpackage

FILE: sv/slsfp_core.sv
// Frame parser core: phase register, length/count/sum registers and the result logic.
// Depends on slsfp_pkg.
module slsfp_core #(
   parameter int MAX_FRAME_LEN = slsfp_pkg::MAX_FRAME_LEN_DFLT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             rx_byte,
   output slsfp_pkg::result_type  result
);
   import slsfp_pkg::*;

   localparam logic [7:0] MaxLen = 8'(MAX_FRAME_LEN);

   phase_type   phase_ff, phase_in;
   logic [7:0]  frame_length_ff, frame_length_in;
   logic [7:0]  bytes_seen_ff, bytes_seen_in;
   logic [31:0] running_sum_ff, running_sum_in;
   logic [31:0] received_sum_ff, received_sum_in;
   logic [7:0]  held_id_ff, held_id_in;

   logic [7:0]  crc_start;
   logic [7:0]  crc_offset;
   logic [31:0] placed_byte;
   logic        last_byte;

   assign crc_start  = frame_length_ff - CHECKSUM_BYTES;
   assign crc_offset = bytes_seen_ff - crc_start;
   assign last_byte  = ({1'b0, bytes_seen_ff} + 9'd1) >= {1'b0, frame_length_ff};

   // Checksum bytes arrive little-endian.
   always_comb begin
      case (crc_offset[1:0])
         2'd0:    placed_byte = {24'd0, rx_byte};
         2'd1:    placed_byte = {16'd0, rx_byte, 8'd0};
         2'd2:    placed_byte = {8'd0, rx_byte, 16'd0};
         default: placed_byte = {rx_byte, 24'd0};
      endcase
   end

   always_comb begin
      phase_in        = phase_ff;
      frame_length_in = frame_length_ff;
      bytes_seen_in   = bytes_seen_ff;
      running_sum_in  = running_sum_ff;
      received_sum_in = received_sum_ff;
      held_id_in      = held_id_ff;
      result          = '0;
      case (phase_ff)
         PH_LEN: begin
            if (rx_byte < MIN_FRAME_LEN || rx_byte >= MaxLen) begin
               phase_in        = PH_HUNT;
               frame_length_in = '0;
               bytes_seen_in   = '0;
               running_sum_in  = '0;
               received_sum_in = '0;
            end else begin
               phase_in        = PH_BODY;
               frame_length_in = rx_byte;
               bytes_seen_in   = '0;
               running_sum_in  = {24'd0, SYNC_BYTE} + {24'd0, rx_byte};
               received_sum_in = '0;
            end
         end
         PH_BODY: begin
            if (bytes_seen_ff == 8'd0) begin
               held_id_in     = rx_byte;
               running_sum_in = running_sum_ff + {24'd0, rx_byte};
            end else if (bytes_seen_ff < crc_start) begin
               running_sum_in = running_sum_ff + {24'd0, rx_byte};
            end else begin
               received_sum_in = received_sum_ff | placed_byte;
            end
            if (last_byte) begin
               // The final byte is always a checksum byte, so the running sum is complete.
               if ((received_sum_ff | placed_byte) == running_sum_ff) begin
                  result.frame_ok   = 1'b1;
                  result.message_id = held_id_ff;
               end else begin
                  result.checksum_error = 1'b1;
               end
               phase_in        = PH_HUNT;
               frame_length_in = '0;
               bytes_seen_in   = '0;
               running_sum_in  = '0;
               received_sum_in = '0;
            end else begin
               bytes_seen_in = bytes_seen_ff + 8'd1;
            end
         end
         default: begin
            phase_in = (rx_byte == SYNC_BYTE) ? PH_LEN : PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HUNT;
         frame_length_ff <= '0;
         bytes_seen_ff   <= '0;
         running_sum_ff  <= '0;
         received_sum_ff <= '0;
         held_id_ff      <= '0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         frame_length_ff <= frame_length_in;
         bytes_seen_ff   <= bytes_seen_in;
         running_sum_ff  <= running_sum_in;
         received_sum_ff <= received_sum_in;
         held_id_ff      <= held_id_in;
      end
   end

   a_body_len_legal: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> (frame_length_ff >= MIN_FRAME_LEN && frame_length_ff < MaxLen))
      else $error("body phase with an illegal frame length");

   a_count_in_frame: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> bytes_seen_ff < frame_length_ff)
      else $error("byte count ran past the frame length");

   a_end_returns_to_hunt: assert property (@(posedge clock) disable iff (reset)
      (accept && (result.frame_ok || result.checksum_error)) |=> phase_ff == PH_HUNT)
      else $error("parser did not resume hunting after a frame ended");

endmodule

FILE: sv/slsfp_rsp_queue.sv
// Two-entry response queue between the parser core and the response channel.
// Depends on slsfp_pkg.
module slsfp_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  slsfp_pkg::result_type  push_data,
   input  logic                   pop,
   output logic                   full,
   output logic                   not_empty,
   output slsfp_pkg::result_type  head
);
   import slsfp_pkg::*;

   result_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = count_ff == 2'd2;
   assign not_empty = count_ff != 2'd0;
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("response queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("response queue read while empty");

   a_ptrs_track_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with the fill count");

endmodule

FILE: sv/sync_length_sum32_frame_parser.sv
// Top level of the sync/length/sum32 frame parser: handshakes, core and response queue.
// Depends on slsfp_pkg, slsfp_core and slsfp_rsp_queue.
//
// This block takes one received byte per request and returns exactly one response per
// request. It hunts for the sync byte 0x55, then takes a length byte L (5 <= L <
// MAX_FRAME_LEN, otherwise the frame is dropped and hunting resumes with the next byte),
// then L further bytes: a message id, L-5 payload bytes and a four-byte little-endian
// checksum. The checksum must equal the 32-bit wrapping sum of the sync, length, id and
// payload bytes. On the byte that ends a frame the response carries frame_ok with the
// message id, or checksum_error; every other response is all zero. Each request is
// handled by the parser core, whose state registers update at the accepting edge and
// whose result is written into a two-entry response queue, so a new request can be
// accepted on every clock cycle while the queue has room and the first response is
// valid in the cycle after its request is accepted. The queue lets a request be taken
// while an earlier response waits; req_stall is raised only when both entries are full.
module sync_length_sum32_frame_parser #(
   parameter int MAX_FRAME_LEN = slsfp_pkg::MAX_FRAME_LEN_DFLT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_frame_ok,
   output logic [7:0] rsp_message_id,
   output logic       rsp_checksum_error
);
   import slsfp_pkg::*;

   logic       req_accept;
   logic       rsp_accept;
   logic       queue_full;
   result_type core_result;
   result_type rsp_head;

   // A request is taken whenever the queue has room; the stall is decoded from the registered fill count.
   assign req_stall  = queue_full;
   assign req_accept = req_valid && !queue_full;
   assign rsp_accept = rsp_valid && !rsp_stall;

   slsfp_core #(
      .MAX_FRAME_LEN(MAX_FRAME_LEN)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .rx_byte (req_rx_byte),
      .result  (core_result)
   );

   slsfp_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (core_result),
      .pop       (rsp_accept),
      .full      (queue_full),
      .not_empty (rsp_valid),
      .head      (rsp_head)
   );

   assign rsp_frame_ok       = rsp_head.frame_ok;
   assign rsp_message_id     = rsp_head.message_id;
   assign rsp_checksum_error = rsp_head.checksum_error;

   // A response never reports success and failure together, and an id only with success.
   a_exclusive_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_frame_ok && rsp_checksum_error))
      else $error("response flags both success and checksum error");

   a_id_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_frame_ok) |-> rsp_message_id == 8'd0)
      else $error("message id reported without a good frame");

   // A request accepted into an empty queue must appear as a response on the next cycle.
   a_response_follows: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !rsp_valid) |=> rsp_valid)
      else $error("accepted request produced no response");

endmodule
